@@ src/sdpa_pkg.sv @@
// ----------------------------------------------------------------------------
// sdpa_pkg: shared types and constants for the attention block
// Request and result payloads, divider chain control, sequencer states and
// the constant-table generators.
// ----------------------------------------------------------------------------
package sdpa_pkg;

    localparam logic [1:0] KIND_KEY   = 2'd0;
    localparam logic [1:0] KIND_VALUE = 2'd1;
    localparam logic [1:0] KIND_MASK  = 2'd2;
    localparam logic [1:0] KIND_QUERY = 2'd3;

    localparam logic [2:0] CFG_SCALE       = 3'd0;
    localparam logic [2:0] CFG_KEY_COUNT   = 3'd1;
    localparam logic [2:0] CFG_HEAD_WIDTH  = 3'd2;
    localparam logic [2:0] CFG_VALUE_WIDTH = 3'd3;
    localparam logic [2:0] CFG_MASK_ENABLE = 3'd4;

    // quotient bits produced by the divider chain, one per cell
    localparam int QUO_W = 17;

    localparam logic signed [31:0] MASKED_SCORE = -32'sd655360000;

    typedef struct packed {
        logic [1:0]         kind;
        logic [5:0]         row;
        logic [5:0]         col;
        logic signed [15:0] data;
        logic               mask_bit;
    } sdpa_in_t;

    typedef struct packed {
        logic signed [15:0] out_value;
        logic [5:0]         out_col;
        logic               last;
    } sdpa_out_t;

    typedef struct packed {
        logic       valid;
        logic       sat;
        logic       neg;
        logic [5:0] col;
        logic       last;
    } div_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DOT,
        ST_DOT_DRAIN,
        ST_EXP,
        ST_ACC,
        ST_ACC_DRAIN
    } seq_state_t;

    function automatic logic [6:0] clamp_cnt(input logic [6:0] v, input int hi);
        if (v == 7'd0) return 7'd1;
        if (int'(v) > hi) return 7'(hi);
        return v;
    endfunction

    // round(4096/sqrt(n)): largest r with (2r-1)^2 * n <= 2^26
    function automatic logic [12:0] inv_sqrt_q12(input int n);
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        logic [63:0] t;
        lo = 64'd1;
        hi = 64'd4096;
        for (int i = 0; i < 14; i++) begin
            if (lo < hi) begin
                mid = (lo + hi + 64'd1) >> 1;
                t = 2 * mid - 64'd1;
                if (t * t * 64'(n) <= 64'h400_0000) lo = mid;
                else hi = mid - 64'd1;
            end
        end
        return 13'(lo);
    endfunction

    // exp(-k/16) in Q1.16 by repeated fixed-point steps
    function automatic logic [16:0] exp_entry(input int k);
        logic [63:0] t;
        t = 64'h1_0000_0000;
        for (int i = 0; i < k; i++) begin
            t = (t * 64'd4034748382 + 64'h8000_0000) >> 32;
        end
        return 17'((t + 64'd32768) >> 16);
    endfunction

endpackage

@@ src/sdpa_ram.sv @@
// ----------------------------------------------------------------------------
// sdpa_ram: generic simple dual-port RAM
// One write port, one read port with registered read data and read enable.
// ----------------------------------------------------------------------------
module sdpa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ src/sdpa_div_cell.sv @@
// ----------------------------------------------------------------------------
// sdpa_div_cell: one restoring-division step
// Resolves one quotient bit and hands remainder and shifted divisor on.
// ----------------------------------------------------------------------------
module sdpa_div_cell #(
    parameter int W = 42
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  sdpa_pkg::div_ctl_t          ctl,
    input  logic [W-1:0]                rem,
    input  logic [W-1:0]                dsh,
    input  logic [sdpa_pkg::QUO_W-1:0]  quo,
    output sdpa_pkg::div_ctl_t          held_ctl,
    output logic [W-1:0]                held_rem,
    output logic [W-1:0]                held_dsh,
    output logic [sdpa_pkg::QUO_W-1:0]  held_quo
);
    import sdpa_pkg::*;

    div_ctl_t         ctl_reg;
    logic [W-1:0]     rem_reg;
    logic [W-1:0]     dsh_reg;
    logic [QUO_W-1:0] quo_reg;
    logic             ge;

    assign ge = (rem >= dsh);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (adv)
        begin
            ctl_reg <= ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg <= ge ? rem - dsh : rem;
            dsh_reg <= dsh >> 1;
            quo_reg <= {quo[QUO_W-2:0], ge};
        end
    end

    assign held_ctl = ctl_reg;
    assign held_rem = rem_reg;
    assign held_dsh = dsh_reg;
    assign held_quo = quo_reg;

endmodule

@@ src/scaled_dot_product_attention.sv @@
// ----------------------------------------------------------------------------
// scaled_dot_product_attention: one-head attention with fixed-point softmax
// Key/value stores, sequenced score and softmax passes, divider cell chain.
// ----------------------------------------------------------------------------
// Load keys, values and mask bits as requests (any order, one per cycle while
// idle); then stream query elements. The query element at column head_width-1
// starts a pass and the request port stalls until the pass has fed its last
// value column into the divider. A pass reads the key store, then the value
// store, one element per cycle, and value-store reads hold while the result
// side stalls. Each value column enters a chain of 17 division cells, one
// quotient bit per cell, and leaves it through the result register; the chain
// drains while the next requests are taken. Memories are never cleared: only
// entries that were written may be read. Mask bits sit in flip-flops that
// reset to keep.
module scaled_dot_product_attention #(
    parameter int MAX_KEYS        = 64,
    parameter int MAX_HEAD        = 64,
    parameter int EXP_TABLE_DEPTH = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  sdpa_pkg::sdpa_in_t  req_data,
    output logic                res_valid,
    input  logic                res_stall,
    output sdpa_pkg::sdpa_out_t res_data,
    input  logic                cfg_wen,
    input  logic [2:0]          cfg_idx,
    input  logic [15:0]         cfg_data
);
    import sdpa_pkg::*;

    localparam int KA     = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int HA     = (MAX_HEAD > 1) ? $clog2(MAX_HEAD) : 1;
    localparam int SDEPTH = MAX_KEYS * MAX_HEAD;
    localparam int SA     = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;
    localparam int EI     = $clog2(EXP_TABLE_DEPTH);
    localparam int MASKN  = (MAX_KEYS < 64) ? MAX_KEYS : 64;
    localparam int MI     = (MASKN > 1) ? $clog2(MASKN) : 1;
    localparam int DOT_W  = 33 + HA;          // exact q*k sum
    localparam int MUL_W  = DOT_W + 17;       // dot * scale
    localparam int SUM_W  = 18 + KA;          // sum of weights
    localparam int ACC_W  = 35 + KA;          // weighted value sum
    localparam int DIV_W  = ACC_W + 2;

    // ---------------- configuration ----------------
    logic [15:0] scale_factor_reg;
    logic [6:0]  key_count_reg;
    logic [6:0]  head_width_reg;
    logic [6:0]  value_width_reg;
    logic        mask_enable_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_factor_reg <= 16'd0;
            key_count_reg    <= 7'd64;
            head_width_reg   <= 7'd64;
            value_width_reg  <= 7'd64;
            mask_enable_reg  <= 1'b0;
        end
        else if (cfg_wen)
        begin
            case (cfg_idx)
                CFG_SCALE:       scale_factor_reg <= cfg_data;
                CFG_KEY_COUNT:   key_count_reg    <= cfg_data[6:0];
                CFG_HEAD_WIDTH:  head_width_reg   <= cfg_data[6:0];
                CFG_VALUE_WIDTH: value_width_reg  <= cfg_data[6:0];
                CFG_MASK_ENABLE: mask_enable_reg  <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    logic [6:0] nk_eff, hw_eff, vw_eff;
    assign nk_eff = clamp_cnt(key_count_reg, MAX_KEYS);
    assign hw_eff = clamp_cnt(head_width_reg, MAX_HEAD);
    assign vw_eff = clamp_cnt(value_width_reg, MAX_HEAD);

    // 1/sqrt(n) and exp(-k/16) tables, folded at elaboration
    logic [12:0] inv_tab [128];
    logic [16:0] exp_tab [EXP_TABLE_DEPTH];
    for (genvar g = 0; g < 128; g++) begin : g_inv
        assign inv_tab[g] = inv_sqrt_q12(g);
    end
    for (genvar g = 0; g < EXP_TABLE_DEPTH; g++) begin : g_exp
        assign exp_tab[g] = exp_entry(g);
    end

    logic [15:0] scale_eff;
    assign scale_eff = (scale_factor_reg != 16'd0) ? scale_factor_reg
                                                   : {3'b000, inv_tab[hw_eff]};

    // ---------------- request side ----------------
    seq_state_t state_reg, state_next;
    logic       req_acc;
    logic       start;
    logic       row_ok, col_ok;

    assign req_stall = (state_reg != ST_IDLE);
    assign req_acc   = req_valid && !req_stall;
    assign row_ok    = int'(req_data.row) < MAX_KEYS;
    assign col_ok    = int'(req_data.col) < MAX_HEAD;
    assign start     = req_acc && (req_data.kind == KIND_QUERY) && col_ok
                       && ({1'b0, req_data.col} == hw_eff - 7'd1);

    logic [SA-1:0] wr_saddr;
    assign wr_saddr = SA'(int'(req_data.row) * MAX_HEAD + int'(req_data.col));

    // mask bits: only rows below MAX_KEYS that the 6-bit row field can reach are stored
    logic [MASKN-1:0] mask_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '1;
        end
        else if (req_acc && req_data.kind == KIND_MASK && int'(req_data.row) < MASKN)
        begin
            mask_reg[req_data.row[MI-1:0]] <= req_data.mask_bit;
        end
    end

    // ---------------- sequencer ----------------
    logic [6:0]  j_reg, j_next, c_reg, c_next, d_reg, d_next;
    logic [6:0]  nk_reg, hw_reg, vw_reg;
    logic [15:0] scale_reg;
    logic        issue_dot, issue_exp, issue_acc;
    logic        adv;

    // dot path stage flags
    logic        v1, f1, l1, v2, f2, l2, v3, v4, v5;
    logic [6:0]  k1, k2, k3, k4, k5;
    // exp pass
    logic        e1_v;
    logic [6:0]  e1_k;
    // weighted sum path
    logic        a1_v, a1_f, a1_l, a1_lc, a2_v, a2_f, a2_l, a2_lc, a3_v, a3_lc;
    logic [6:0]  a1_d, a2_d, a3_d;

    always_comb
    begin
        state_next = state_reg;
        j_next     = j_reg;
        c_next     = c_reg;
        d_next     = d_reg;
        issue_dot  = 1'b0;
        issue_exp  = 1'b0;
        issue_acc  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_DOT;
                    j_next     = 7'd0;
                    c_next     = 7'd0;
                end
            end
            ST_DOT:
            begin
                issue_dot = 1'b1;
                if (c_reg == hw_reg - 7'd1)
                begin
                    c_next = 7'd0;
                    j_next = j_reg + 7'd1;
                    if (j_reg == nk_reg - 7'd1)
                    begin
                        state_next = ST_DOT_DRAIN;
                    end
                end
                else
                begin
                    c_next = c_reg + 7'd1;
                end
            end
            ST_DOT_DRAIN:
            begin
                if (v5 && k5 == nk_reg - 7'd1)
                begin
                    state_next = ST_EXP;
                    j_next     = 7'd0;
                end
            end
            ST_EXP:
            begin
                if (j_reg < nk_reg)
                begin
                    issue_exp = 1'b1;
                    j_next    = j_reg + 7'd1;
                end
                if (e1_v && e1_k == nk_reg - 7'd1)
                begin
                    state_next = ST_ACC;
                    j_next     = 7'd0;
                    d_next     = 7'd0;
                end
            end
            ST_ACC:
            begin
                if (adv)
                begin
                    issue_acc = 1'b1;
                    if (j_reg == nk_reg - 7'd1)
                    begin
                        j_next = 7'd0;
                        d_next = d_reg + 7'd1;
                        if (d_reg == vw_reg - 7'd1)
                        begin
                            state_next = ST_ACC_DRAIN;
                        end
                    end
                    else
                    begin
                        j_next = j_reg + 7'd1;
                    end
                end
            end
            ST_ACC_DRAIN:
            begin
                if (!a1_v && !a2_v && !a3_v)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            j_reg     <= 7'd0;
            c_reg     <= 7'd0;
            d_reg     <= 7'd0;
        end
        else
        begin
            state_reg <= state_next;
            j_reg     <= j_next;
            c_reg     <= c_next;
            d_reg     <= d_next;
        end
    end

    // pass parameters are frozen at the start request
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            nk_reg    <= nk_eff;
            hw_reg    <= hw_eff;
            vw_reg    <= vw_eff;
            scale_reg <= scale_eff;
        end
    end

    // ---------------- memories ----------------
    logic signed [15:0] q_rd, k_rd, v_rd;
    logic [31:0]        s_rd;
    logic               s_we;
    logic [KA-1:0]      s_waddr;
    logic [31:0]        s_wdata;
    logic               s_re;
    logic               acc_phase;

    assign acc_phase = (state_reg == ST_ACC) || (state_reg == ST_ACC_DRAIN);
    assign s_re      = acc_phase ? adv : 1'b1;

    sdpa_ram #(.WIDTH(16), .DEPTH(MAX_HEAD)) u_qbuf (
        .clk   (clk),
        .we    (req_acc && req_data.kind == KIND_QUERY && col_ok),
        .waddr (HA'(req_data.col)),
        .wdata (req_data.data),
        .re    (1'b1),
        .raddr (HA'(c_reg)),
        .rdata (q_rd)
    );

    sdpa_ram #(.WIDTH(16), .DEPTH(SDEPTH)) u_kstore (
        .clk   (clk),
        .we    (req_acc && req_data.kind == KIND_KEY && row_ok && col_ok),
        .waddr (wr_saddr),
        .wdata (req_data.data),
        .re    (1'b1),
        .raddr (SA'(int'(j_reg) * MAX_HEAD + int'(c_reg))),
        .rdata (k_rd)
    );

    sdpa_ram #(.WIDTH(16), .DEPTH(SDEPTH)) u_vstore (
        .clk   (clk),
        .we    (req_acc && req_data.kind == KIND_VALUE && row_ok && col_ok),
        .waddr (wr_saddr),
        .wdata (req_data.data),
        .re    (adv),
        .raddr (SA'(int'(j_reg) * MAX_HEAD + int'(d_reg))),
        .rdata (v_rd)
    );

    sdpa_ram #(.WIDTH(32), .DEPTH(MAX_KEYS)) u_score (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .re    (s_re),
        .raddr (KA'(j_reg)),
        .rdata (s_rd)
    );

    // ---------------- score pass ----------------
    logic signed [31:0]       prod2;
    logic signed [DOT_W-1:0]  acc_d, dsum, dot3;
    logic signed [MUL_W-1:0]  mul4, mag4, rnd4, sv4;
    logic signed [31:0]       sc4, s5, mx_reg;
    logic                     masked4;

    assign dsum = (f2 ? '0 : acc_d) + DOT_W'(prod2);

    // round half away from zero, then saturate to Q16.16
    always_comb
    begin
        mag4 = mul4[MUL_W-1] ? -mul4 : mul4;
        rnd4 = (mag4 + MUL_W'(20'h80000)) >>> 20;
        sv4  = mul4[MUL_W-1] ? -rnd4 : rnd4;
        if (sv4[MUL_W-1:31] == '0 || sv4[MUL_W-1:31] == '1)
        begin
            sc4 = sv4[31:0];
        end
        else
        begin
            sc4 = sv4[MUL_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
    end

    assign masked4 = mask_enable_reg && (int'(k4) < MASKN) && !mask_reg[k4[MI-1:0]];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1 <= 1'b0;
            v2 <= 1'b0;
            v3 <= 1'b0;
            v4 <= 1'b0;
            v5 <= 1'b0;
        end
        else
        begin
            v1 <= issue_dot;
            v2 <= v1;
            v3 <= v2 && l2;
            v4 <= v3;
            v5 <= v4;
        end
    end

    always_ff @(posedge clk)
    begin
        f1    <= (c_reg == 7'd0);
        l1    <= (c_reg == hw_reg - 7'd1);
        k1    <= j_reg;
        f2    <= f1;
        l2    <= l1;
        k2    <= k1;
        prod2 <= q_rd * k_rd;
        if (v2)
        begin
            acc_d <= dsum;
        end
        dot3  <= dsum;
        k3    <= k2;
        mul4  <= MUL_W'(dot3) * MUL_W'($signed({1'b0, scale_reg}));
        k4    <= k3;
        s5    <= masked4 ? MASKED_SCORE : sc4;
        k5    <= k4;
        if (v5 && (k5 == 7'd0 || s5 > mx_reg))
        begin
            mx_reg <= s5;
        end
    end

    // ---------------- softmax weights ----------------
    logic signed [33:0] diff;
    logic [21:0]        idx;
    logic [16:0]        w_exp;
    logic [SUM_W-1:0]   sum_reg;

    assign diff  = 34'(mx_reg) - 34'($signed(s_rd)) + 34'sd2048;
    assign idx   = diff[33:12];
    assign w_exp = (int'(idx) < EXP_TABLE_DEPTH) ? exp_tab[idx[EI-1:0]] : 17'd0;

    assign s_we    = v5 || e1_v;
    assign s_waddr = v5 ? KA'(k5) : KA'(e1_k);
    assign s_wdata = v5 ? s5 : 32'(w_exp);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e1_v <= 1'b0;
        end
        else
        begin
            e1_v <= issue_exp;
        end
    end

    always_ff @(posedge clk)
    begin
        e1_k <= j_reg;
        if (start)
        begin
            sum_reg <= '0;
        end
        else if (e1_v)
        begin
            sum_reg <= sum_reg + SUM_W'(w_exp);
        end
    end

    // ---------------- weighted value sums ----------------
    logic signed [33:0]      prod_a;
    logic signed [ACC_W-1:0] acc_w, wsum, a3_acc, mag_a;
    logic [DIV_W-1:0]        num0, den0;
    logic                    ovf0;

    assign wsum = (a2_f ? '0 : acc_w) + ACC_W'(prod_a);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a1_v <= 1'b0;
            a2_v <= 1'b0;
            a3_v <= 1'b0;
        end
        else if (adv)
        begin
            a1_v <= issue_acc;
            a2_v <= a1_v;
            a3_v <= a2_v && a2_l;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a1_f   <= (j_reg == 7'd0);
            a1_l   <= (j_reg == nk_reg - 7'd1);
            a1_d   <= d_reg;
            a1_lc  <= (d_reg == vw_reg - 7'd1);
            a2_f   <= a1_f;
            a2_l   <= a1_l;
            a2_d   <= a1_d;
            a2_lc  <= a1_lc;
            prod_a <= $signed({1'b0, s_rd[16:0]}) * v_rd;
            if (a2_v)
            begin
                acc_w <= wsum;
            end
            a3_acc <= wsum;
            a3_d   <= a2_d;
            a3_lc  <= a2_lc;
        end
    end

    // divider operands: (2|acc| + sum) / (2 sum), quotient limited to 17 bits
    assign mag_a = a3_acc[ACC_W-1] ? -a3_acc : a3_acc;
    assign num0  = (DIV_W'(mag_a) << 1) + DIV_W'(sum_reg);
    assign den0  = DIV_W'(sum_reg) << 1;
    assign ovf0  = num0 >= (den0 << QUO_W);

    // ---------------- divider cell chain ----------------
    div_ctl_t         ctl_c [QUO_W+1];
    logic [DIV_W-1:0] rem_c [QUO_W+1];
    logic [DIV_W-1:0] dsh_c [QUO_W+1];
    logic [QUO_W-1:0] quo_c [QUO_W+1];

    assign ctl_c[0] = '{valid: a3_v, sat: ovf0, neg: a3_acc[ACC_W-1],
                        col: a3_d[5:0], last: a3_lc};
    assign rem_c[0] = num0;
    assign dsh_c[0] = den0 << (QUO_W - 1);
    assign quo_c[0] = '0;

    for (genvar g = 0; g < QUO_W; g++) begin : g_cell
        sdpa_div_cell #(.W(DIV_W)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (adv),
            .ctl      (ctl_c[g]),
            .rem      (rem_c[g]),
            .dsh      (dsh_c[g]),
            .quo      (quo_c[g]),
            .held_ctl (ctl_c[g+1]),
            .held_rem (rem_c[g+1]),
            .held_dsh (dsh_c[g+1]),
            .held_quo (quo_c[g+1])
        );
    end

    // ---------------- result register ----------------
    logic               res_valid_reg;
    sdpa_out_t          res_data_reg;
    div_ctl_t           tail;
    logic [QUO_W-1:0]   qt;
    logic signed [15:0] res_val;

    assign tail = ctl_c[QUO_W];
    assign qt   = quo_c[QUO_W];
    assign adv  = !res_valid_reg || !res_stall;

    always_comb
    begin
        if (tail.neg)
        begin
            res_val = (tail.sat || qt > 17'd32768) ? -16'sd32768 : 16'(-qt);
        end
        else
        begin
            res_val = (tail.sat || qt > 17'd32767) ? 16'sd32767 : 16'(qt);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            res_valid_reg <= tail.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_data_reg <= '{out_value: res_val, out_col: tail.col, last: tail.last};
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    // ---------------- assertions ----------------
    // score pipeline must be empty once the softmax pass begins
    a_dot_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXP || state_reg == ST_ACC) |-> !(v1 || v2 || v3 || v4 || v5))
        else $error("score pipeline busy outside score pass");

    // the maximum always carries full weight, so the divisor is never zero
    a_sum_nz: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ACC) |-> (sum_reg != '0))
        else $error("weight sum is zero");

    // a pass starts only on an accepted query request
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && state_next == ST_DOT)
            |-> (req_valid && req_data.kind == KIND_QUERY))
        else $error("pass started without query request");

endmodule

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for scaled_dot_product_attention
// Loads both stores and then streams query rows under several register
// settings, with random request gaps and result stalls. A scoreboard class
// predicts each row's softmax-weighted value sums and checks every result
// in order.
// ----------------------------------------------------------------------------
module tb_top;
    import sdpa_pkg::*;

    localparam int         LIMIT        = 1_000_000;
    localparam int         SETTLE       = 40;    // settle time after the last result
    localparam int         TARGET_ITEMS = 380;
    localparam logic [2:0] CFG_SPARE    = 3'd5;  // unused index, must be ignored

    // ------------------------------------------------------------------------
    // Attention predictor and result scoreboard
    // ------------------------------------------------------------------------
    class attn_scoreboard;
        logic signed [15:0] keys [64][64];
        logic signed [15:0] vals [64][64];
        logic signed [15:0] qbuf [64];
        bit                 keep [64];
        bit [15:0]          scale_reg;
        bit [6:0]           nk_reg;
        bit [6:0]           hw_reg;
        bit [6:0]           vw_reg;
        bit                 mask_on;
        bit [16:0]          exp_tab [256];
        sdpa_out_t          expected_q [$];
        int                 errors;
        int                 checked;
        int                 passes;

        function new();
            bit [63:0] t;
            t = 64'h1_0000_0000;
            // exp(-k/16) table, Q1.16, built by repeated rounded steps
            for (int k = 0; k < 256; k++)
            begin
                exp_tab[k] = 17'((t + 64'd32768) >> 16);
                t = (t * 64'd4034748382 + 64'h8000_0000) >> 32;
            end
            foreach (keep[i]) keep[i] = 1'b1;
            scale_reg = 16'd0;
            nk_reg    = 7'd64;
            hw_reg    = 7'd64;
            vw_reg    = 7'd64;
            mask_on   = 1'b0;
        endfunction

        function int clamp64(bit [6:0] v);
            if (v == 7'd0) return 1;
            if (v > 7'd64) return 64;
            return int'(v);
        endfunction

        function void write_reg(bit [2:0] idx, bit [15:0] v);
            case (idx)
                CFG_SCALE:       scale_reg = v;
                CFG_KEY_COUNT:   nk_reg    = v[6:0];
                CFG_HEAD_WIDTH:  hw_reg    = v[6:0];
                CFG_VALUE_WIDTH: vw_reg    = v[6:0];
                CFG_MASK_ENABLE: mask_on   = v[0];
                default: ;
            endcase
        endfunction

        // Update stores; a query element in the last head column runs a pass.
        function void note_request(sdpa_in_t r);
            int        nk;
            int        hw;
            int        vw;
            longint    scl;
            longint    score [64];
            longint    wt [64];
            longint    dot;
            longint    s;
            longint    mx;
            longint    sum;
            longint    acc;
            longint    q;
            bit [63:0] mag;
            bit [63:0] idx;
            sdpa_out_t e;
            case (r.kind)
                KIND_KEY:   keys[r.row][r.col] = r.data;
                KIND_VALUE: vals[r.row][r.col] = r.data;
                KIND_MASK:  keep[r.row] = r.mask_bit;
                default:
                begin
                    qbuf[r.col] = r.data;
                    hw = clamp64(hw_reg);
                    if (int'(r.col) == hw - 1)
                    begin
                        nk = clamp64(nk_reg);
                        vw = clamp64(vw_reg);
                        scl = 0;
                        if (scale_reg != 16'd0)
                            scl = longint'(scale_reg);
                        else
                        begin
                            // round(4096/sqrt(hw)) by bisection
                            longint lo;
                            longint hi;
                            longint mid;
                            lo = 1;
                            hi = 4096;
                            while (lo < hi)
                            begin
                                mid = (lo + hi + 1) / 2;
                                if ((2*mid - 1) * (2*mid - 1) * hw <= 64'sd67108864)
                                    lo = mid;
                                else
                                    hi = mid - 1;
                            end
                            scl = lo;
                        end
                        mx = 0;
                        for (int j = 0; j < nk; j++)
                        begin
                            dot = 0;
                            for (int c = 0; c < hw; c++)
                                dot += longint'(qbuf[c]) * longint'(keys[j][c]);
                            s = dot * scl;
                            // >> 20, ties away from zero, into Q16.16
                            if (s >= 0) s = (s + 64'sd524288) >>> 20;
                            else        s = -((-s + 64'sd524288) >>> 20);
                            if (s > 64'sd2147483647)  s = 64'sd2147483647;
                            if (s < -64'sd2147483648) s = -64'sd2147483648;
                            if (mask_on && !keep[j]) s = longint'(MASKED_SCORE);
                            score[j] = s;
                            if (j == 0 || s > mx) mx = s;
                        end
                        sum = 0;
                        for (int j = 0; j < nk; j++)
                        begin
                            idx = 64'(mx - score[j] + 2048) >> 12;
                            wt[j] = (idx < 64'd256) ? longint'(exp_tab[idx]) : 0;
                            sum += wt[j];
                        end
                        if (sum <= 0) sum = 1;
                        for (int d = 0; d < vw; d++)
                        begin
                            acc = 0;
                            for (int j = 0; j < nk; j++)
                                acc += wt[j] * longint'(vals[j][d]);
                            mag = (acc >= 0) ? 64'(acc) : 64'(-acc);
                            mag = (2 * mag + 64'(sum)) / (2 * 64'(sum));
                            q = (acc >= 0) ? longint'(mag) : -longint'(mag);
                            if (q > 32767)  q = 32767;
                            if (q < -32768) q = -32768;
                            e.out_value = 16'(q);
                            e.out_col   = 6'(d);
                            e.last      = (d == vw - 1);
                            expected_q.push_back(e);
                        end
                        passes++;
                    end
                end
            endcase
        endfunction

        function void check_result(sdpa_out_t got);
            sdpa_out_t e;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result value=%0d col=%0d last=%0d",
                         $time, got.out_value, got.out_col, got.last);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            checked++;
            if (got.out_value !== e.out_value)
            begin
                $display("%0t: out_value expected %0d actual %0d",
                         $time, e.out_value, got.out_value);
                errors++;
            end
            if (got.out_col !== e.out_col)
            begin
                $display("%0t: out_col expected %0d actual %0d",
                         $time, e.out_col, got.out_col);
                errors++;
            end
            if (got.last !== e.last)
            begin
                $display("%0t: last expected %0d actual %0d",
                         $time, e.last, got.last);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and DUT
    // ------------------------------------------------------------------------
    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       req_valid = 1'b0;
    logic       req_stall;
    sdpa_in_t   req_data  = '0;
    logic       res_valid;
    logic       res_stall = 1'b0;
    sdpa_out_t  res_data;
    logic       cfg_wen   = 1'b0;
    logic [2:0] cfg_idx   = '0;
    logic [15:0] cfg_data = '0;

    attn_scoreboard sb = new();

    int  tx_pct = 14;    // request idle odds, percent per cycle
    int  rx_pct = 64;    // result stall odds, percent per cycle
    int  cycles = 0;
    int  queries = 0;    // query elements sent
    int  items = 0;      // requests of any kind sent
    bit  qseen [64];     // query buffer columns written so far
    int  hw_now = 64;

    scaled_dot_product_attention DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data),
        .cfg_wen   (cfg_wen),
        .cfg_idx   (cfg_idx),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Watchdog: well above the slowest legal run.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Result side: check accepted results, stall at random.
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
            sb.check_result(res_data);
        res_stall <= (rx_pct > 0) && ($urandom_range(99) < rx_pct);
    end

    // ------------------------------------------------------------------------
    // Request helpers
    // ------------------------------------------------------------------------
    function automatic sdpa_in_t make_req(logic [1:0] k, int r, int c,
                                          logic [15:0] d, logic m);
        sdpa_in_t it;
        it.kind     = k;
        it.row      = 6'(r);
        it.col      = 6'(c);
        it.data     = d;
        it.mask_bit = m;
        return it;
    endfunction

    // Mostly random data, with the signed extremes and zero mixed in.
    function automatic logic [15:0] pick_data();
        case ($urandom_range(9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // True when every query column below the head width has been written.
    function automatic bit query_buf_ready(int hw);
        for (int c = 0; c < hw; c++)
            if (!qseen[c]) return 1'b0;
        return 1'b1;
    endfunction

    // Present one request, holding it until the block takes it.
    task automatic send(sdpa_in_t it);
        int gap;
        gap = 0;
        while (tx_pct > 0 && $urandom_range(99) < tx_pct) gap++;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= it;
        do @(posedge clk); while (req_stall);
        sb.note_request(it);
        items++;
        if (it.kind == KIND_QUERY)
        begin
            qseen[it.col] = 1'b1;
            queries++;
        end
    endtask

    task automatic send_query_row(int hw);
        for (int c = 0; c < hw; c++)
            send(make_req(KIND_QUERY, $urandom_range(63), c, pick_data(),
                          1'($urandom_range(1))));
    endtask

    // Hold requests off until every expected result is back, then settle.
    task automatic drain();
        req_valid <= 1'b0;
        while (sb.expected_q.size() > 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] v);
        cfg_wen  <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= v;
        @(posedge clk);
        sb.write_reg(idx, v);
    endtask

    // Only called with the block idle (after drain).
    task automatic set_config(logic [15:0] scl, int nk, int hw, int vw, bit men);
        write_reg(CFG_SCALE, scl);
        write_reg(CFG_KEY_COUNT, 16'(nk));
        write_reg(CFG_HEAD_WIDTH, 16'(hw));
        write_reg(CFG_VALUE_WIDTH, 16'(vw));
        write_reg(CFG_MASK_ENABLE, 16'(men));
        cfg_wen <= 1'b0;
        hw_now = sb.clamp64(7'(hw));
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        int       phase;
        int       phase_qry;
        int       nk;
        int       hw;
        int       vw;
        logic [15:0] scl;
        sdpa_in_t it;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill column 0 of every row, plus an 8 x 4 corner, in both stores;
        // every pass below reads only these entries.
        for (int r = 0; r < 64; r++)
            for (int c = 0; c < ((r < 8) ? 4 : 1); c++)
            begin
                send(make_req(KIND_KEY, r, c, 16'($urandom), 1'b0));
                send(make_req(KIND_VALUE, r, c, 16'($urandom), 1'b0));
            end
        drain();

        // Directed: register extremes, out-of-range counts, auto scale.
        set_config(16'd0, 127, 1, 1, 1'b0);
        send(make_req(KIND_KEY, 0, 0, 16'h8000, 1'b0));
        send(make_req(KIND_KEY, 1, 0, 16'h7FFF, 1'b0));
        send(make_req(KIND_VALUE, 0, 0, 16'h7FFF, 1'b0));
        send(make_req(KIND_VALUE, 1, 0, 16'h8000, 1'b0));
        send(make_req(KIND_QUERY, 0, 0, 16'h8000, 1'b0));
        send(make_req(KIND_QUERY, 63, 0, 16'h7FFF, 1'b1));
        send(make_req(KIND_QUERY, 5, 5, 16'h1234, 1'b0));   // past head width
        send(make_req(KIND_QUERY, 0, 0, 16'h0000, 1'b0));
        drain();

        // Every key masked: weights come out uniform.
        set_config(16'hFFFF, 3, 2, 2, 1'b1);
        for (int r = 0; r < 3; r++)
            send(make_req(KIND_MASK, r, 0, 16'h0, 1'b0));
        send(make_req(KIND_QUERY, 0, 0, 16'h8000, 1'b0));
        send(make_req(KIND_QUERY, 0, 1, 16'h8000, 1'b0));
        // one key kept again
        send(make_req(KIND_MASK, 1, 0, 16'h0, 1'b1));
        send(make_req(KIND_QUERY, 0, 1, 16'h7FFF, 1'b0));
        drain();

        // Zero counts clamp to one; spare index must be ignored.
        set_config(16'd1, 0, 0, 0, 1'b1);
        write_reg(CFG_SPARE, 16'hFFFF);
        cfg_wen <= 1'b0;
        send(make_req(KIND_QUERY, 0, 0, 16'h7FFF, 1'b0));
        drain();

        // Random phases: mostly full query rows, some store/mask noise.
        phase = 0;
        while (items < TARGET_ITEMS)
        begin
            if (items < 250)      begin tx_pct = 14; rx_pct = 64; end
            else if (items < 320) begin tx_pct = 64; rx_pct = 14; end
            else                  begin tx_pct = 0;  rx_pct = 0;  end
            if (phase == 3)
            begin
                nk = 64; hw = 1; vw = 1;
            end
            else
            begin
                nk = $urandom_range(1, 8);
                hw = $urandom_range(1, 4);
                vw = $urandom_range(1, 4);
            end
            scl = ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom);
            drain();
            set_config(scl, nk, hw, vw, 1'($urandom_range(1)));
            phase_qry = 0;
            while (phase_qry < ((phase == 3) ? 1 : 24))
            begin
                if (phase == 5 && phase_qry == 12)
                    drain();   // sender holds off until all results are back
                if (phase == 3 || $urandom_range(9) < 7)
                begin
                    send_query_row(hw_now);
                    phase_qry += hw_now;
                end
                else
                begin
                    it = make_req(2'($urandom_range(3)), $urandom_range(63),
                                  $urandom_range(63), pick_data(),
                                  1'($urandom_range(1)));
                    // a stray last-column query must not read unwritten columns
                    if (it.kind == KIND_QUERY && int'(it.col) == hw_now - 1
                        && !query_buf_ready(hw_now))
                        it.kind = KIND_MASK;
                    send(it);
                    if (it.kind == KIND_QUERY) phase_qry++;
                end
            end
            phase++;
        end

        drain();
        $display("Sent %0d requests (%0d query elements) over %0d phases; %0d passes.",
                 items, queries, phase, sb.passes);
        $display("Checked %0d results, %0d mismatches.", sb.checked, sb.errors);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
